/* design/bfr_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and codes for the bayer frame rotator
// no dependencies; compiled first
package bfr_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 1;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int MIN_WIDTH      = 3;
  localparam int MIN_HEIGHT     = 1;
  localparam int PHASE_SHIFT    = 1;

  localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 11'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 1'b0,
    CFG_SRC_HEIGHT = 1'b1
  } bfr_cfg_idx_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EMIT = 1'b1
  } bfr_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_ACCESS,
    S_RESULT
  } bfr_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic calc;
    logic access;
    logic out_load;
  } bfr_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_emit;
    logic out_free;
  } bfr_sts_t;

endpackage

/* design/bfr_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for the input and result transactions
// depends on bfr_pkg
interface bfr_in_if;
  import bfr_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output cmd, output pixel_in, input ready);
  modport sink (input valid, input cmd, input pixel_in, output ready);
endinterface

interface bfr_out_if;
  import bfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             last_pixel;

  modport source (output valid, output pixel_out, output last_pixel, input ready);
  modport sink (input valid, input pixel_out, input last_pixel, output ready);
endinterface

/* design/bayer_frame_rotate_90_top.sv */
`timescale 1ns / 1ps
// top level of the bayer frame rotator: controller plus datapath
// depends on bfr_pkg, bfr_if, bfr_ctrl, bfr_dp
//
//  port group   dir   handshake          payload
//  in_chan      in    valid/ready        cmd (load/emit), pixel_in
//  out_chan     out   valid/ready        pixel_out, last_pixel
//  cfg_*        in    write enable only  cfg_idx (0 width, 1 height), cfg_wdata
//
// a load transaction passes through accept, address calc and store write
// an emit transaction passes through accept, address calc, store read and result load;
//   the sequence is set by the single-port frame store and its registered read
// the output register holds one finished result, so the next transaction is
//   accepted while that result waits; a second emit waits for the slot to free up
// synchronous active-low reset clears counters and state and sets config to 640x480; the store is not cleared
module bayer_frame_rotate_90_top #(
  parameter int MAX_WIDTH  = bfr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bfr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bfr_in_if.sink                        in_chan,
  bfr_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [bfr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bfr_pkg::CFG_W-1:0]     cfg_wdata
);
  import bfr_pkg::*;

  // command and status between the two halves
  bfr_ctl_t ctl;
  bfr_sts_t sts;

  // sequencer: one transaction at a time through calc and store access
  bfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .ctl      (ctl),
    .sts      (sts)
  );

  // counters, address generation, frame store and result register
  bfr_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_cmd    (in_chan.cmd),
    .in_pixel  (in_chan.pixel_in),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_pixel (out_chan.pixel_out),
    .out_last  (out_chan.last_pixel),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

/* design/bfr_ctrl.sv */
`timescale 1ns / 1ps
// sequencing state machine: accept, address calc, store access, result hand-off
// depends on bfr_pkg
module bfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output bfr_pkg::bfr_ctl_t ctl,
  input  bfr_pkg::bfr_sts_t sts
);
  import bfr_pkg::*;

  bfr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CALC;
      end
      S_CALC: begin
        state_nxt = S_ACCESS;
      end
      S_ACCESS: begin
        state_nxt = sts.is_emit ? S_RESULT : S_IDLE;
      end
      S_RESULT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = (state_r == S_IDLE);
    ctl.capture  = in_valid && (state_r == S_IDLE);
    ctl.calc     = (state_r == S_CALC);
    ctl.access   = (state_r == S_ACCESS);
    ctl.out_load = (state_r == S_RESULT) && sts.out_free;
  end

  a_accept_then_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ctl.calc)
    else $error("accepted transaction not followed by address calc");

  a_access_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.access |-> $past(ctl.calc))
    else $error("store access without preceding address calc");

  a_out_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> sts.out_free && sts.is_emit)
    else $error("result loaded for a load command or into a busy slot");

endmodule

/* design/bfr_dp.sv */
`timescale 1ns / 1ps
// datapath: config registers, raster counters, frame store, output register
// depends on bfr_pkg
module bfr_dp #(
  parameter int MAX_WIDTH  = bfr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bfr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bfr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bfr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_cmd,
  input  logic [bfr_pkg::PIX_W-1:0]     in_pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfr_pkg::PIX_W-1:0]     out_pixel,
  output logic                          out_last,
  input  bfr_pkg::bfr_ctl_t             ctl,
  output bfr_pkg::bfr_sts_t             sts
);
  import bfr_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HH    = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = ((WW > CFG_W) ? WW : CFG_W) + 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // configuration and effective frame size
  logic [CFG_W-1:0] src_width_r, src_height_r;
  logic [WW-1:0]    w_eff_r, w_sat;
  logic [HH-1:0]    h_eff_r, h_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (bfr_cfg_idx_t'(cfg_idx))
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (XW'(src_width_r) < XW'(MIN_WIDTH)) begin
      w_sat = WW'(MIN_WIDTH);
    end else if (XW'(src_width_r) > XW'(MAX_WIDTH)) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(src_width_r);
    end
    if (XW'(src_height_r) < XW'(MIN_HEIGHT)) begin
      h_sat = HH'(MIN_HEIGHT);
    end else if (XW'(src_height_r) > XW'(MAX_HEIGHT)) begin
      h_sat = HH'(MAX_HEIGHT);
    end else begin
      h_sat = HH'(src_height_r);
    end
  end

  always_ff @(posedge clk) begin
    w_eff_r <= w_sat;
    h_eff_r <= h_sat;
  end

  // captured transaction
  bfr_cmd_t         cmd_r;
  logic [PIX_W-1:0] pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= CMD_LOAD;
    end else if (ctl.capture) begin
      cmd_r <= bfr_cmd_t'(in_cmd);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) pix_r <= in_pixel;
  end

  // raster counters
  logic [HW-1:0] load_row_r, load_row_nxt, emit_col_r, emit_col_nxt;
  logic [CW-1:0] load_col_r, load_col_nxt, emit_row_r, emit_row_nxt;

  logic [HW-1:0] ld_row, em_col;
  logic [CW-1:0] ld_col, em_row;
  logic [WW-1:0] src_col_w;
  logic [AW-1:0] addr_nxt, addr_r;
  logic          zero_nxt, zero_r, last_nxt, last_r;

  always_comb begin
    // restart a pair left outside the frame by a size change
    if ((HH'(load_row_r) >= h_eff_r) || (WW'(load_col_r) >= w_eff_r)) begin
      ld_row = '0;
      ld_col = '0;
    end else begin
      ld_row = load_row_r;
      ld_col = load_col_r;
    end
    if ((WW'(emit_row_r) >= w_eff_r) || (HH'(emit_col_r) >= h_eff_r)) begin
      em_row = '0;
      em_col = '0;
    end else begin
      em_row = emit_row_r;
      em_col = emit_col_r;
    end

    // load advance
    if (WW'(ld_col) + WW'(1) >= w_eff_r) begin
      load_col_nxt = '0;
      load_row_nxt = (HH'(ld_row) + HH'(1) >= h_eff_r) ? '0 : ld_row + HW'(1);
    end else begin
      load_col_nxt = ld_col + CW'(1);
      load_row_nxt = ld_row;
    end

    // emit advance: rotated frame has w rows of h pixels
    if (HH'(em_col) + HH'(1) >= h_eff_r) begin
      emit_col_nxt = '0;
      emit_row_nxt = (WW'(em_row) + WW'(1) >= w_eff_r) ? '0 : em_row + CW'(1);
    end else begin
      emit_col_nxt = em_col + HW'(1);
      emit_row_nxt = em_row;
    end

    // output row 0 is the last source column, the rest shift by the skip
    if (em_row == '0) begin
      src_col_w = w_eff_r - WW'(1);
    end else begin
      src_col_w = w_eff_r - WW'(PHASE_SHIFT + 1) - WW'(em_row);
    end
    zero_nxt = (em_row != '0) && (XW'(em_row) + XW'(PHASE_SHIFT + 2) > XW'(w_eff_r));
    last_nxt = (WW'(em_row) == w_eff_r - WW'(1)) && (HH'(em_col) == h_eff_r - HH'(1));

    if (cmd_r == CMD_EMIT) begin
      addr_nxt = AW'(em_col) * AW'(MAX_WIDTH) + AW'(src_col_w[CW-1:0]);
    end else begin
      addr_nxt = AW'(ld_row) * AW'(MAX_WIDTH) + AW'(ld_col);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r <= '0;
      load_col_r <= '0;
      emit_row_r <= '0;
      emit_col_r <= '0;
    end else if (ctl.calc) begin
      if (cmd_r == CMD_EMIT) begin
        emit_row_r <= emit_row_nxt;
        emit_col_r <= emit_col_nxt;
      end else begin
        load_row_r <= load_row_nxt;
        load_col_r <= load_col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      addr_r <= addr_nxt;
      zero_r <= zero_nxt;
      last_r <= last_nxt;
    end
  end

  // frame store, one port, registered read
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (ctl.access && (cmd_r == CMD_LOAD)) mem[addr_r] <= pix_r;
    if (ctl.access) rd_r <= mem[addr_r];
  end

  // output register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_pixel_r <= zero_r ? '0 : rd_r;
      out_last_r  <= last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pixel    = out_pixel_r;
  assign out_last     = out_last_r;
  assign sts.is_emit  = (cmd_r == CMD_EMIT);
  assign sts.out_free = !out_valid_r || out_ready;

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.calc && (cmd_r == CMD_EMIT) && last_nxt |=> (emit_row_r == '0) && (emit_col_r == '0))
    else $error("emit counters did not wrap after the final pixel");

  a_row0_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.calc && (cmd_r == CMD_EMIT) && (em_row == '0) |=> !zero_r)
    else $error("first rotated row flagged as padding");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> !out_valid_r || out_ready)
    else $error("pending result overwritten");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for bayer_frame_rotate_90_top: directed rows, then random frames
// depends on bfr_pkg, bfr_in_if/bfr_out_if and the rotator rtl
module tb;
  import bfr_pkg::*;

  localparam int MAX_W          = DEF_MAX_WIDTH;
  localparam int MAX_H          = DEF_MAX_HEIGHT;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int DRAIN_CYCLES   = 8;       // a load leaves no result, give it time to land
  localparam int HOLD_AFTER     = 150;     // results seen before the long output hold-off
  localparam int HOLD_CYCLES    = 300;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int REPORT_LIMIT   = 10;

  // one rotated pixel as it leaves the block
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } rot_pix_t;

  // directed stimulus rows; cfg rows rewrite both frame registers
  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_EMIT,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [PIX_W-1:0] pix;
    logic             typed;      // 1: result below is known by inspection
    logic [PIX_W-1:0] want_pix;
    logic             want_last;
    logic [CFG_W-1:0] cfg_w;
    logic [CFG_W-1:0] cfg_h;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    // out-of-range registers saturate to the smallest frame: 3 wide, 1 tall
    '{ROW_CFG,  8'h00, 1'b0, 8'h00, 1'b0, 11'd0,    11'd0},
    '{ROW_LOAD, 8'h00, 1'b0, 8'h00, 1'b0, 11'd0,    11'd0},
    '{ROW_LOAD, 8'h5A, 1'b0, 8'h00, 1'b0, 11'd0,    11'd0},
    '{ROW_LOAD, 8'hFF, 1'b0, 8'h00, 1'b0, 11'd0,    11'd0},
    // output row 0 is the last source column, the last two rows are zero
    '{ROW_EMIT, 8'h00, 1'b1, 8'hFF, 1'b0, 11'd0,    11'd0},
    '{ROW_EMIT, 8'h00, 1'b1, 8'h00, 1'b0, 11'd0,    11'd0},
    '{ROW_EMIT, 8'h00, 1'b1, 8'h00, 1'b1, 11'd0,    11'd0},
    // emit counters wrap after the final pixel
    '{ROW_EMIT, 8'hFF, 1'b1, 8'hFF, 1'b0, 11'd0,    11'd0},
    // widen to 4: emit position stays inside the frame and carries on at row 1
    '{ROW_CFG,  8'h00, 1'b0, 8'h00, 1'b0, 11'd4,    11'd0},
    '{ROW_LOAD, 8'h11, 1'b0, 8'h00, 1'b0, 11'd0,    11'd0},
    '{ROW_LOAD, 8'h22, 1'b0, 8'h00, 1'b0, 11'd0,    11'd0},
    '{ROW_LOAD, 8'h33, 1'b0, 8'h00, 1'b0, 11'd0,    11'd0},
    '{ROW_LOAD, 8'h44, 1'b0, 8'h00, 1'b0, 11'd0,    11'd0},
    '{ROW_EMIT, 8'h00, 1'b0, 8'h00, 1'b0, 11'd0,    11'd0},
    '{ROW_EMIT, 8'h00, 1'b1, 8'h00, 1'b0, 11'd0,    11'd0},
    // narrow back to 3: emit row 3 falls outside and restarts at the origin
    '{ROW_CFG,  8'h00, 1'b0, 8'h00, 1'b0, 11'd3,    11'd0},
    '{ROW_EMIT, 8'h00, 1'b1, 8'h33, 1'b0, 11'd0,    11'd0},
    '{ROW_EMIT, 8'h00, 1'b1, 8'h00, 1'b0, 11'd0,    11'd0},
    '{ROW_EMIT, 8'h00, 1'b1, 8'h00, 1'b1, 11'd0,    11'd0},
    // height above the limit saturates to the tallest frame
    '{ROW_CFG,  8'h00, 1'b0, 8'h00, 1'b0, 11'd3,    11'd2047},
    '{ROW_LOAD, 8'h01, 1'b0, 8'h00, 1'b0, 11'd0,    11'd0},
    '{ROW_LOAD, 8'h80, 1'b0, 8'h00, 1'b0, 11'd0,    11'd0},
    '{ROW_LOAD, 8'h7F, 1'b0, 8'h00, 1'b0, 11'd0,    11'd0},
    '{ROW_EMIT, 8'h00, 1'b1, 8'h7F, 1'b0, 11'd0,    11'd0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  bfr_in_if  in_if ();
  bfr_out_if out_if ();

  bayer_frame_rotate_90_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // rotation predictor: own copy of frame store, registers and raster counters
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] frame_pix [0:MAX_W*MAX_H-1];
  bit               frame_written [0:MAX_W*MAX_H-1];   // guards reads of never-written pixels
  logic [CFG_W-1:0] width_reg  = SRC_WIDTH_RST;
  logic [CFG_W-1:0] height_reg = SRC_HEIGHT_RST;
  int unsigned      ld_row = 0, ld_col = 0;
  int unsigned      em_row = 0, em_col = 0;

  rot_pix_t         pending_pix_q [$];   // rotated pixels still owed by the block
  int unsigned      items_sent   = 0;
  int unsigned      results_seen = 0;
  int unsigned      mismatches   = 0;
  int unsigned      cycle_cnt    = 0;
  int unsigned      burst_left   = 0;

  // registers saturate into the legal frame range
  function automatic int unsigned frame_w();
    if (width_reg < MIN_WIDTH) return MIN_WIDTH;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned frame_h();
    if (height_reg < MIN_HEIGHT) return MIN_HEIGHT;
    if (height_reg > MAX_H) return MAX_H;
    return height_reg;
  endfunction

  // source column feeding rotated row k, or -1 for the two zero rows at the bottom;
  // the skipped column keeps the bayer phase
  function automatic int src_col_of(int unsigned k, int unsigned w);
    if (k == 0) return w - 1;
    if (k <= w - 3) return w - 1 - PHASE_SHIFT - k;
    return -1;
  endfunction

  // would the next emit read only pixels that were loaded
  function automatic bit emit_is_safe();
    int unsigned w, h, k, r;
    int          c;
    w = frame_w();
    h = frame_h();
    k = em_row;
    r = em_col;
    if (k >= w || r >= h) begin
      k = 0;
      r = 0;
    end
    c = src_col_of(k, w);
    if (c < 0) return 1'b1;
    return frame_written[r * MAX_W + c];
  endfunction

  function automatic void rotate_predict(input bfr_cmd_t c, input logic [PIX_W-1:0] p,
                                         output bit has_res, output rot_pix_t res);
    int unsigned w, h, idx;
    int          col;
    w = frame_w();
    h = frame_h();
    has_res = 1'b0;
    res = '0;
    if (c == CMD_LOAD) begin
      // a register change can leave the load position outside the frame
      if (ld_row >= h || ld_col >= w) begin
        ld_row = 0;
        ld_col = 0;
      end
      idx = ld_row * MAX_W + ld_col;
      frame_pix[idx] = p;
      frame_written[idx] = 1'b1;
      ld_col++;
      if (ld_col >= w) begin
        ld_col = 0;
        ld_row = (ld_row + 1 >= h) ? 0 : ld_row + 1;
      end
    end else begin
      if (em_row >= w || em_col >= h) begin
        em_row = 0;
        em_col = 0;
      end
      col = src_col_of(em_row, w);
      res.pix  = (col < 0) ? '0 : frame_pix[em_col * MAX_W + col];
      res.last = (em_row == w - 1) && (em_col == h - 1);
      has_res  = 1'b1;
      em_col++;
      if (em_col >= h) begin
        em_col = 0;
        em_row = (em_row + 1 >= w) ? 0 : em_row + 1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------

  // offer one transaction, wait for it to be taken, then idle if the burst is over
  task automatic send_item(input bfr_cmd_t c, input logic [PIX_W-1:0] p,
                           input bit typed, input rot_pix_t typed_res);
    bit       has_res;
    rot_pix_t res;
    in_if.valid    <= 1'b1;
    in_if.cmd      <= c;
    in_if.pixel_in <= p;
    do @(posedge clk); while (!in_if.ready);
    rotate_predict(c, p, has_res, res);
    if (has_res) pending_pix_q.insert(pending_pix_q.size(), typed ? typed_res : res);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // mostly short bursts, now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  // random transaction; an emit that would read an unloaded pixel becomes a load
  task automatic send_random(input int unsigned emit_pct, output bit was_emit);
    bfr_cmd_t c;
    c = ($urandom_range(0, 99) < emit_pct) ? CMD_EMIT : CMD_LOAD;
    if (c == CMD_EMIT && !emit_is_safe()) c = CMD_LOAD;
    was_emit = (c == CMD_EMIT);
    send_item(c, PIX_W'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // drop valid, let every owed result come back, then let trailing loads settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_pix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // two back-to-back register writes; only called with the block idle
  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SRC_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx   <= CFG_SRC_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_reg  = w;
    height_reg = h;
  endtask

  // one frame setting; structured phases load a whole frame, then read a whole
  // rotated frame with loads sprinkled in, otherwise a free mix of both commands
  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input int unsigned n_items, input bit structured);
    int unsigned fw, fh, emits;
    bit          was_emit;
    wait_idle();
    set_frame(w, h);
    fw = frame_w();
    fh = frame_h();
    if (structured) begin
      repeat (fw * fh) send_random(0, was_emit);
      emits = 0;
      while (emits < fw * fh) begin
        send_random(80, was_emit);
        if (was_emit) emits++;
      end
    end else begin
      repeat (n_items) send_random(50, was_emit);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input rot_pix_t want, input rot_pix_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s: expected pix=%02h last=%0b, got pix=%02h last=%0b",
               $realtime, what, want.pix, want.last, got.pix, got.last);
  endtask

  // every accepted result is compared with the oldest owed pixel
  always @(posedge clk) begin
    rot_pix_t want, got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.pix  = out_if.pixel_out;
      got.last = out_if.last_pixel;
      results_seen++;
      if (pending_pix_q.size() == 0) begin
        note_mismatch("result with nothing owed", '0, got);
      end else begin
        want = pending_pix_q.pop_front();
        if (got.pix !== want.pix || got.last !== want.last)
          note_mismatch("rotated pixel mismatch", want, got);
      end
    end
  end

  // receiver: a random ready pattern held for a span and then redrawn, plus one long hold-off
  // once the run is well under way, so the output slot fills and input stalls
  initial begin
    int unsigned ready_pct;
    int unsigned span;
    bit          hold_done;
    ready_pct = 100;
    span      = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (span == 0) begin
          span = 50;
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 80;
            2: ready_pct = 50;
            default: ready_pct = 15;
          endcase
        end
        span--;
        out_if.ready <= ($urandom_range(0, 99) < ready_pct);
        @(posedge clk);
      end
    end
  end

  // watchdog
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned      phase_no;
    int unsigned      item_goal;
    dir_row_t         row;
    logic [CFG_W-1:0] rw, rh;

    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_SRC_WIDTH;
    cfg_wdata      <= '0;
    in_if.valid    <= 1'b0;
    in_if.cmd      <= CMD_LOAD;
    in_if.pixel_in <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: extremes, wraps, saturation and counters left outside the frame
    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      case (row.kind)
        ROW_CFG: begin
          wait_idle();
          set_frame(row.cfg_w, row.cfg_h);
        end
        ROW_LOAD: send_item(CMD_LOAD, row.pix, 1'b0, '0);
        default: send_item(CMD_EMIT, row.pix, row.typed, {row.want_pix, row.want_last});
      endcase
    end

    // random frames; a few fixed phases hit the widest and tallest settings
    item_goal = items_sent + RANDOM_ITEMS;
    phase_no  = 0;
    while (items_sent < item_goal) begin
      case (phase_no)
        3: run_phase(11'd1024, 11'd1, 1100, 1'b0);       // widest frame, one row
        4: run_phase(11'd1500, 11'd1, 40, 1'b0);         // width beyond the limit
        6: run_phase(CFG_W'($urandom_range(3, 6)), 11'd1024, 80, 1'b0);
        default: begin
          case ($urandom_range(0, 9))
            0: rw = CFG_W'($urandom_range(0, 2));          // saturates up to 3
            1: rw = CFG_W'(MIN_WIDTH);
            default: rw = CFG_W'($urandom_range(3, 10));
          endcase
          case ($urandom_range(0, 9))
            0: rh = '0;                                    // saturates up to 1
            1: rh = CFG_W'(MIN_HEIGHT);
            default: rh = CFG_W'($urandom_range(1, 8));
          endcase
          run_phase(rw, rh, $urandom_range(20, 60), $urandom_range(0, 3) != 0);
        end
      endcase
      phase_no++;
    end

    wait_idle();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
